>>> hdl/tmr_pkg.sv
// Package for the tick timer with reload: command and register codes, item structs
// and the result struct of the shared wrap unit. Depends on nothing.
`default_nettype none
package tmr_pkg;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_NONE  = 2'd3
	} tmr_cmd_t;

	typedef enum logic [2:0] {
		SEL_DIV  = 3'd0,
		SEL_TIMA = 3'd1,
		SEL_TMA  = 3'd2,
		SEL_TAC  = 3'd3,
		SEL_IF   = 3'd4
	} tmr_sel_t;

	localparam logic [7:0] TIMER_IRQ_MASK = 8'h04;
	localparam int unsigned CTRL_ENABLE_BIT = 2;
	localparam logic [7:0] UNMAPPED_READ = 8'hff;

	localparam int unsigned ACC_W = 17;
	localparam int unsigned STEPS_W = 13;
	localparam int unsigned PRESCALE_W = 10;

	typedef struct packed {
		logic [1:0]  command;
		logic [2:0]  reg_select;
		logic [7:0]  write_data;
		logic [15:0] tick_cycles;
	} tmr_in_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [7:0] irq_flags;
	} tmr_out_t;

	typedef struct packed {
		logic [STEPS_W-1:0] next_steps;
		logic [7:0]         next_counter;
		logic               wrapped;
		logic               last;
	} tmr_wrap_t;

endpackage
`default_nettype wire

>>> hdl/tick_timer_with_reload_top.sv
// Top level of the tick timer with reload: timer registers, bus decode and sequencer.
// Depends on tmr_pkg and tmr_wrap_unit.
//
//   port      dir   kind       content
//   start     in    request    an item is taken when start is high and busy is low
//   req       in    item       tmr_in_t: command, reg_select, write_data, tick_cycles
//   busy      out   status     high while a tick works through counter wraps
//   done      out   strobe     one cycle, marks rsp
//   rsp       out   result     tmr_out_t: read_data, irq_flags
//
// A read, a write, a tick with counting off, or an enabled tick that causes no
// counter wrap gives its result on the cycle after it is taken.
// An enabled tick that causes counter wraps keeps busy high while the wrap unit
// works through them at one wrap per cycle; at most 4159 wraps are possible.
// Reset clears every register. The receiver cannot stall; done lasts one cycle.
`default_nettype none
module tick_timer_with_reload_top import tmr_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire tmr_in_t req,
	output logic         busy,
	output logic         done,
	output tmr_out_t     rsp
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} tmr_state_t;

	tmr_state_t state_q;
	logic [15:0]           div_q;
	logic [PRESCALE_W-1:0] accum_q;
	logic [7:0]            tima_q;
	logic [7:0]            tma_q;
	logic [7:0]            tac_q;
	logic [7:0]            irq_q;
	logic [STEPS_W-1:0]    steps_q;
	logic                  done_q;
	tmr_out_t              rsp_q;

	logic                  accept;
	logic [ACC_W-1:0]      acc_sum;
	logic [STEPS_W-1:0]    acc_steps;
	logic [PRESCALE_W-1:0] acc_rem;
	logic [7:0]            rd_data;
	logic [7:0]            irq_next;
	tmr_wrap_t             wrap;
	logic [STEPS_W-1:0]    unit_steps;

	assign accept = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp = rsp_q;

	assign acc_sum = {{(ACC_W-PRESCALE_W){1'b0}}, accum_q} + {1'b0, req.tick_cycles};

	always_comb begin
		case (tac_q[1:0])
			2'd0: begin
				acc_steps = STEPS_W'(acc_sum >> 10);
				acc_rem = acc_sum[9:0];
			end
			2'd1: begin
				acc_steps = STEPS_W'(acc_sum >> 4);
				acc_rem = {6'd0, acc_sum[3:0]};
			end
			2'd2: begin
				acc_steps = STEPS_W'(acc_sum >> 6);
				acc_rem = {4'd0, acc_sum[5:0]};
			end
			default: begin
				acc_steps = STEPS_W'(acc_sum >> 8);
				acc_rem = {2'd0, acc_sum[7:0]};
			end
		endcase
	end

	always_comb begin
		case (req.reg_select)
			SEL_DIV:  rd_data = div_q[15:8];
			SEL_TIMA: rd_data = tima_q;
			SEL_TMA:  rd_data = tma_q;
			SEL_TAC:  rd_data = tac_q;
			SEL_IF:   rd_data = irq_q;
			default:  rd_data = UNMAPPED_READ;
		endcase
	end

	always_comb begin
		irq_next = irq_q;
		if (req.command == CMD_WRITE && req.reg_select == SEL_IF) begin
			irq_next = req.write_data;
		end
	end

	assign unit_steps = (state_q == ST_RUN) ? steps_q : acc_steps;

	tmr_wrap_unit u_wrap (
		.steps   (unit_steps),
		.counter (tima_q),
		.reload  (tma_q),
		.res     (wrap)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			div_q <= '0;
			accum_q <= '0;
			tima_q <= '0;
			tma_q <= '0;
			tac_q <= '0;
			irq_q <= '0;
			steps_q <= '0;
			done_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.command)
							CMD_READ: begin
								done_q <= 1'b1;
								rsp_q.read_data <= rd_data;
								rsp_q.irq_flags <= irq_q;
							end
							CMD_WRITE: begin
								done_q <= 1'b1;
								rsp_q.read_data <= '0;
								rsp_q.irq_flags <= irq_next;
								case (req.reg_select)
									SEL_DIV:  div_q <= '0;
									SEL_TIMA: tima_q <= req.write_data;
									SEL_TMA:  tma_q <= req.write_data;
									SEL_TAC:  tac_q <= req.write_data;
									SEL_IF:   irq_q <= req.write_data;
									default:  ;
								endcase
							end
							CMD_TICK: begin
								div_q <= div_q + req.tick_cycles;
								rsp_q.read_data <= '0;
								if (tac_q[CTRL_ENABLE_BIT]) begin
									accum_q <= acc_rem;
									tima_q <= wrap.next_counter;
									if (wrap.last) begin
										done_q <= 1'b1;
										rsp_q.irq_flags <= irq_q;
									end else begin
										irq_q <= irq_q | TIMER_IRQ_MASK;
										steps_q <= wrap.next_steps;
										state_q <= ST_RUN;
									end
								end else begin
									done_q <= 1'b1;
									rsp_q.irq_flags <= irq_q;
								end
							end
							default: begin
								done_q <= 1'b1;
								rsp_q.read_data <= '0;
								rsp_q.irq_flags <= irq_q;
							end
						endcase
					end
				end
				ST_RUN: begin
					tima_q <= wrap.next_counter;
					steps_q <= wrap.next_steps;
					if (wrap.last) begin
						done_q <= 1'b1;
						rsp_q.read_data <= '0;
						rsp_q.irq_flags <= irq_q;
						state_q <= ST_IDLE;
					end else begin
						irq_q <= irq_q | TIMER_IRQ_MASK;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("Result strobe while the sequencer is still running.");

	a_bus_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.command != CMD_TICK) |=> done)
		else $error("A bus item did not finish in one cycle.");

	a_run_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && wrap.wrapped) |=> (steps_q < $past(steps_q)))
		else $error("Pending increments did not shrink after a wrap.");

	a_run_sets_irq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> ((irq_q & TIMER_IRQ_MASK) == TIMER_IRQ_MASK))
		else $error("Wrap in progress without the timer interrupt flag.");

endmodule
`default_nettype wire

>>> hdl/tmr_wrap_unit.sv
// Shared wrap unit: advances the counter by the pending increments up to the next wrap.
// Depends on tmr_pkg.
`default_nettype none
module tmr_wrap_unit import tmr_pkg::*; (
	input  wire logic [STEPS_W-1:0] steps,
	input  wire logic [7:0]         counter,
	input  wire logic [7:0]         reload,
	output tmr_wrap_t               res
);

	logic [8:0]         to_wrap;
	logic [STEPS_W-1:0] to_wrap_ext;

	assign to_wrap = 9'd256 - {1'b0, counter};
	assign to_wrap_ext = {{(STEPS_W-9){1'b0}}, to_wrap};

	always_comb begin
		res = '0;
		if (steps < to_wrap_ext) begin
			res.last = 1'b1;
			res.wrapped = 1'b0;
			res.next_steps = '0;
			res.next_counter = counter + steps[7:0];
		end else begin
			res.last = 1'b0;
			res.wrapped = 1'b1;
			res.next_steps = steps - to_wrap_ext;
			res.next_counter = reload;
		end
	end

endmodule
`default_nettype wire
